// ----- sv/csd_pkg.sv -----
`timescale 1ns / 1ps
// csd_pkg: shared types and codes for the cbor stream decoder
// no dependencies

package csd_pkg;

  localparam int unsigned ArgW = 64;
  localparam int unsigned LenW = 32;

  localparam logic [4:0] INFO_ONE_BYTE   = 5'd24;
  localparam logic [4:0] INFO_EIGHT_BYTE = 5'd27;

  localparam logic [2:0] MAJOR_BYTES = 3'd2;
  localparam logic [2:0] MAJOR_TEXT  = 3'd3;
  localparam logic [2:0] MAJOR_MAP   = 3'd5;

  localparam logic [3:0] KIND_PAYLOAD = 4'd8;
  localparam logic [3:0] KIND_ERROR   = 4'd9;

  localparam logic ERR_RESERVED_INFO = 1'b0;
  localparam logic ERR_LONG_LENGTH   = 1'b1;

  typedef struct packed {
    logic [3:0]      kind;
    logic [ArgW-1:0] arg;
    logic [7:0]      pbyte;
    logic            plast;
    logic            ecode;
  } csd_event_t;

  typedef struct packed {
    logic err_mode;
    logic in_payload;
  } csd_status_t;

endpackage

// ----- sv/csd_stream_if.sv -----
`timescale 1ns / 1ps
// csd_byte_if and csd_event_if: valid/ready channels of the decoder
// depends on csd_pkg for the argument width

interface csd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink (input valid, input in_byte, output ready);
endinterface

interface csd_event_if;
  logic                    valid;
  logic                    ready;
  logic [3:0]              event_kind;
  logic [csd_pkg::ArgW-1:0] arg_value;
  logic [7:0]              payload_byte;
  logic                    payload_last;
  logic                    error_code;

  modport source (
    output valid, output event_kind, output arg_value, output payload_byte,
    output payload_last, output error_code, input ready
  );
  modport sink (
    input valid, input event_kind, input arg_value, input payload_byte,
    input payload_last, input error_code, output ready
  );
endinterface

// ----- sv/csd_in_stage.sv -----
`timescale 1ns / 1ps
// csd_in_stage: input register of the decoder
// depends on csd_byte_if

module csd_in_stage (
  input  logic         clk_i,
  input  logic         rst_ni,
  csd_byte_if.sink     in_i,
  input  logic         out_free_i,
  output logic         step_o,
  output logic [7:0]   byte_o
);

  logic       valid_q;
  logic       valid_d;
  logic [7:0] byte_q;

  assign step_o     = valid_q && out_free_i;
  assign in_i.ready = !valid_q || out_free_i;
  assign byte_o     = byte_q;

  always_comb begin
    valid_d = valid_q;
    if (in_i.ready) begin
      valid_d = in_i.valid;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      byte_q <= in_i.in_byte;
    end
  end

endmodule

// ----- sv/csd_parser.sv -----
`timescale 1ns / 1ps
// csd_parser: head, argument and payload state machine of the decoder
// depends on csd_pkg

module csd_parser (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 step_i,
  input  logic [7:0]           byte_i,
  output logic                 ev_valid_o,
  output csd_pkg::csd_event_t  ev_o,
  output csd_pkg::csd_status_t status_o
);
  import csd_pkg::*;

  typedef enum logic [1:0] {
    MODE_HEADER,
    MODE_ARG,
    MODE_PAYLOAD,
    MODE_ERROR
  } mode_e;

  mode_e           mode_q, mode_d;
  logic [2:0]      major_q, major_d;
  logic [3:0]      left_q, left_d;
  logic [ArgW-1:0] accum_q, accum_d;
  logic [LenW-1:0] plen_q, plen_d;

  logic            found;
  logic            fin;
  logic [2:0]      fin_major;
  logic [ArgW-1:0] fin_arg;
  logic [2:0]      hd_major;
  logic [4:0]      hd_info;
  logic [3:0]      left_dec;
  logic [LenW-1:0] plen_dec;

  assign hd_major = byte_i[7:5];
  assign hd_info  = byte_i[4:0];
  assign left_dec = left_q - 4'd1;
  assign plen_dec = plen_q - LenW'(1);

  always_comb begin
    mode_d    = mode_q;
    major_d   = major_q;
    left_d    = left_q;
    accum_d   = accum_q;
    plen_d    = plen_q;
    found     = 1'b0;
    fin       = 1'b0;
    fin_major = major_q;
    fin_arg   = accum_q;
    ev_o      = '0;

    unique case (mode_q)
      MODE_HEADER: begin
        major_d = hd_major;
        if (hd_info < INFO_ONE_BYTE) begin
          fin       = 1'b1;
          fin_major = hd_major;
          fin_arg   = ArgW'(hd_info);
        end else if (hd_info > INFO_EIGHT_BYTE) begin
          found    = 1'b1;
          mode_d   = MODE_ERROR;
          ev_o.kind  = KIND_ERROR;
          ev_o.ecode = ERR_RESERVED_INFO;
        end else if (hd_info == INFO_EIGHT_BYTE && hd_major >= MAJOR_BYTES &&
                     hd_major <= MAJOR_MAP) begin
          found    = 1'b1;
          mode_d   = MODE_ERROR;
          ev_o.kind  = KIND_ERROR;
          ev_o.ecode = ERR_LONG_LENGTH;
        end else begin
          left_d  = 4'd1 << hd_info[1:0];
          accum_d = '0;
          mode_d  = MODE_ARG;
        end
      end
      MODE_ARG: begin
        accum_d = {accum_q[ArgW-9:0], byte_i};
        left_d  = left_dec;
        if (left_dec == 4'd0) begin
          fin       = 1'b1;
          fin_major = major_q;
          fin_arg   = {accum_q[ArgW-9:0], byte_i};
        end
      end
      MODE_PAYLOAD: begin
        found      = 1'b1;
        plen_d     = plen_dec;
        ev_o.kind  = KIND_PAYLOAD;
        ev_o.pbyte = byte_i;
        ev_o.plast = (plen_dec == '0);
        if (plen_dec == '0) begin
          mode_d = MODE_HEADER;
        end
      end
      MODE_ERROR: begin
        mode_d = MODE_ERROR;
      end
      default: begin
        mode_d = MODE_ERROR;
      end
    endcase

    if (fin) begin
      found     = 1'b1;
      mode_d    = MODE_HEADER;
      ev_o.kind = {1'b0, fin_major};
      ev_o.arg  = fin_arg;
      if (fin_major == MAJOR_BYTES || fin_major == MAJOR_TEXT) begin
        plen_d = fin_arg[LenW-1:0];
        if (fin_arg[LenW-1:0] != '0) begin
          mode_d = MODE_PAYLOAD;
        end
      end
    end
  end

  assign ev_valid_o          = step_i && found;
  assign status_o.err_mode   = (mode_q == MODE_ERROR);
  assign status_o.in_payload = (mode_q == MODE_PAYLOAD);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_HEADER;
      major_q <= '0;
      left_q  <= '0;
      plen_q  <= '0;
    end else if (step_i) begin
      mode_q  <= mode_d;
      major_q <= major_d;
      left_q  <= left_d;
      plen_q  <= plen_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_i) begin
      accum_q <= accum_d;
    end
  end

endmodule

// ----- sv/csd_out_stage.sv -----
`timescale 1ns / 1ps
// csd_out_stage: result register driving the event channel
// depends on csd_pkg and csd_event_if

module csd_out_stage (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                step_i,
  input  logic                ev_valid_i,
  input  csd_pkg::csd_event_t ev_i,
  output logic                out_free_o,
  csd_event_if.source         out_o
);
  import csd_pkg::*;

  logic       valid_q;
  logic       valid_d;
  csd_event_t ev_q;

  assign out_free_o = !valid_q || out_o.ready;

  always_comb begin
    valid_d = valid_q;
    if (step_i) begin
      valid_d = ev_valid_i;
    end else if (out_o.ready) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_i && ev_valid_i) begin
      ev_q <= ev_i;
    end
  end

  assign out_o.valid        = valid_q;
  assign out_o.event_kind   = ev_q.kind;
  assign out_o.arg_value    = ev_q.arg;
  assign out_o.payload_byte = ev_q.pbyte;
  assign out_o.payload_last = ev_q.plast;
  assign out_o.error_code   = ev_q.ecode;

endmodule

// ----- sv/cbor_stream_decoder.sv -----
`timescale 1ns / 1ps
// cbor_stream_decoder: streaming cbor head decoder, one stream byte per item
// depends on csd_pkg, csd_stream_if, csd_in_stage, csd_parser, csd_out_stage
//
// usage:
//   in_i carries one encoded byte per item; out_o carries one event per
//   completed head, one per string payload byte, or a single error event.
//   bytes that only extend an argument give no event; after an error every
//   later byte is taken and dropped until reset.
// path: an accepted byte waits in the input register, then the parser feeds its
//   event into the result register that drives out_o.
// throughput: one byte per cycle while out_o takes events, set by the combinational
//   parser update between the input register and the result register.
// reset: returns to head parsing with both registers empty; no clearing
//   pass is needed.
// stalls: while out_o holds an event that is not taken, the pending byte
//   waits in the input register and in_i.ready drops once that is full;
//   holding the byte keeps every event in order with none lost.

module cbor_stream_decoder (
  input  logic        clk_i,
  input  logic        rst_ni,
  csd_byte_if.sink    in_i,
  csd_event_if.source out_o
);
  import csd_pkg::*;

  logic        step;
  logic [7:0]  s1_byte;
  logic        out_free;
  logic        ev_valid;
  csd_event_t  ev;
  csd_status_t status;

  csd_in_stage u_in (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_i),
    .out_free_i (out_free),
    .step_o     (step),
    .byte_o     (s1_byte)
  );

  csd_parser u_parser (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .step_i     (step),
    .byte_i     (s1_byte),
    .ev_valid_o (ev_valid),
    .ev_o       (ev),
    .status_o   (status)
  );

  csd_out_stage u_out (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .step_i     (step),
    .ev_valid_i (ev_valid),
    .ev_i       (ev),
    .out_free_o (out_free),
    .out_o      (out_o)
  );

`ifndef SYNTHESIS
  a_err_sticky : assert property (@(posedge clk_i) disable iff (!rst_ni)
    status.err_mode |=> status.err_mode)
    else $error("error mode left without reset");

  a_err_silent : assert property (@(posedge clk_i) disable iff (!rst_ni)
    status.err_mode |-> !ev_valid)
    else $error("event produced in error mode");

  a_last_kind : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.payload_last) |-> (out_o.event_kind == KIND_PAYLOAD))
    else $error("last flag on a non-payload event");

  a_step_room : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && !out_o.ready) |-> !step)
    else $error("parser advanced into a stalled result register");

  a_payload_kind : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (status.in_payload && ev_valid) |-> (ev.kind == KIND_PAYLOAD))
    else $error("non-payload event inside a string");
`endif

endmodule

// ----- tb/cbor_stream_decoder_tb.sv -----
`timescale 1ns / 1ps
// cbor_stream_decoder_tb: self-checking bench for the streaming cbor head decoder
// drives random and directed byte streams, predicts every event and checks it
// depends on csd_pkg, csd_stream_if and cbor_stream_decoder

module cbor_stream_decoder_tb;
  import csd_pkg::*;

  typedef enum logic [1:0] {
    PM_HEADER,
    PM_ARG,
    PM_PAYLOAD,
    PM_ERROR
  } parse_mode_e;

  localparam logic [2:0] MAJOR_UINT   = 3'd0;
  localparam logic [2:0] MAJOR_NEGINT = 3'd1;
  localparam logic [2:0] MAJOR_ARRAY  = 3'd4;
  localparam logic [2:0] MAJOR_TAG    = 3'd6;
  localparam logic [2:0] MAJOR_SIMPLE = 3'd7;

  localparam logic [4:0] INFO_TWO_BYTE     = 5'd25;
  localparam logic [4:0] INFO_RESERVED_MIN = 5'd28;
  localparam logic [4:0] INFO_RESERVED_MAX = 5'd31;

  localparam int unsigned STREAM_BYTES = 1550;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned CYCLE_LIMIT  = 600000;

  logic clk;
  logic rst_n;

  csd_byte_if  in_if ();
  csd_event_if out_if ();

  cbor_stream_decoder dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_i  (in_if.sink),
    .out_o (out_if.source)
  );

  // decoder shadow state
  parse_mode_e     dec_mode;
  logic [2:0]      dec_major;
  logic [3:0]      dec_arg_left;
  logic [ArgW-1:0] dec_arg;
  logic [LenW-1:0] dec_str_left;

  csd_event_t event_q[$];
  int         err_cnt;
  int         bytes_sent;
  int         cycle_cnt;
  bit         src_calm;
  bit         snk_calm;

  initial begin
    clk = 1'b0;
  end

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("cbor_stream_decoder verification failed");
      $finish;
    end
  end

  function automatic int pick_gap();
    if ($urandom_range(0, 99) < 85) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 40);
  endfunction

  // advances the shadow state by one byte, returns 1 when an event is due
  function bit decode_byte(input logic [7:0] b, output csd_event_t ev);
    logic [2:0]      maj;
    logic [4:0]      inf;
    bit              head_done;
    logic [ArgW-1:0] head_arg;
    ev = '0;
    decode_byte = 1'b0;
    head_done = 1'b0;
    head_arg = '0;
    case (dec_mode)
      PM_HEADER: begin
        maj = b[7:5];
        inf = b[4:0];
        dec_major = maj;
        if (inf < INFO_ONE_BYTE) begin
          head_done = 1'b1;
          head_arg = {{(ArgW - 5){1'b0}}, inf};
        end else if (inf >= INFO_RESERVED_MIN) begin
          dec_mode = PM_ERROR;
          ev.kind = KIND_ERROR;
          ev.ecode = ERR_RESERVED_INFO;
          decode_byte = 1'b1;
        end else if (inf == INFO_EIGHT_BYTE && maj >= MAJOR_BYTES && maj <= MAJOR_MAP) begin
          dec_mode = PM_ERROR;
          ev.kind = KIND_ERROR;
          ev.ecode = ERR_LONG_LENGTH;
          decode_byte = 1'b1;
        end else begin
          dec_arg_left = 4'd1 << (inf - INFO_ONE_BYTE);
          dec_arg = '0;
          dec_mode = PM_ARG;
        end
      end
      PM_ARG: begin
        dec_arg = {dec_arg[ArgW-9:0], b};
        if (dec_arg_left != 0) begin
          dec_arg_left = dec_arg_left - 4'd1;
        end
        if (dec_arg_left == 0) begin
          head_done = 1'b1;
          head_arg = dec_arg;
        end
      end
      PM_PAYLOAD: begin
        if (dec_str_left != 0) begin
          dec_str_left = dec_str_left - LenW'(1);
        end
        ev.kind = KIND_PAYLOAD;
        ev.pbyte = b;
        ev.plast = (dec_str_left == 0);
        if (dec_str_left == 0) begin
          dec_mode = PM_HEADER;
        end
        decode_byte = 1'b1;
      end
      default: begin
      end
    endcase
    if (head_done) begin
      dec_mode = PM_HEADER;
      if (dec_major == MAJOR_BYTES || dec_major == MAJOR_TEXT) begin
        dec_str_left = head_arg[LenW-1:0];
        if (dec_str_left != 0) begin
          dec_mode = PM_PAYLOAD;
        end
      end
      ev.kind = {1'b0, dec_major};
      ev.arg = head_arg;
      decode_byte = 1'b1;
    end
  endfunction

  task automatic send_byte(input logic [7:0] b);
    int         gap;
    csd_event_t ev;
    gap = 0;
    if (!src_calm && $urandom_range(0, 2) == 0) begin
      gap = pick_gap();
    end
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.in_byte <= b;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    if (decode_byte(b, ev)) begin
      event_q.push_back(ev);
    end
    bytes_sent++;
  endtask

  // random byte that never opens an error head or a long string
  task automatic send_noise();
    logic [7:0] b;
    b = 8'($urandom_range(0, 255));
    if (dec_mode == PM_HEADER && b[4:0] > INFO_ONE_BYTE &&
        ((b[7:5] >= MAJOR_BYTES && b[7:5] <= MAJOR_MAP) || b[4:0] >= INFO_RESERVED_MIN)) begin
      b[4:0] = 5'($urandom_range(0, 24));
    end
    send_byte(b);
  endtask

  task automatic sync_to_head();
    while (dec_mode != PM_HEADER) send_noise();
  endtask

  task automatic send_head_item();
    logic [2:0]      maj;
    logic [4:0]      inf;
    logic [ArgW-1:0] arg;
    int              form;
    int              nbytes;
    int              len;
    maj = 3'($urandom_range(0, 7));
    nbytes = 0;
    if (maj == MAJOR_BYTES || maj == MAJOR_TEXT) begin
      len = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 8) : $urandom_range(9, 40);
      arg = ArgW'(len);
      form = $urandom_range(0, 3);
      if (form == 0 && len >= 24) begin
        form = 1;
      end
    end else begin
      case ($urandom_range(0, 7))
        0: arg = '0;
        1: arg = '1;
        default: arg = {$urandom, $urandom};
      endcase
      if (maj == MAJOR_ARRAY || maj == MAJOR_MAP) begin
        form = $urandom_range(0, 3);
      end else begin
        form = $urandom_range(0, 4);
      end
    end
    if (form == 0) begin
      inf = (maj == MAJOR_BYTES || maj == MAJOR_TEXT) ? arg[4:0] : 5'($urandom_range(0, 23));
    end else begin
      inf = INFO_ONE_BYTE + 5'(form - 1);
      nbytes = 1 << (form - 1);
    end
    send_byte({maj, inf});
    for (int i = nbytes - 1; i >= 0; i--) begin
      send_byte(arg[i*8 +: 8]);
    end
    if (maj == MAJOR_BYTES || maj == MAJOR_TEXT) begin
      repeat (len) send_byte(8'($urandom_range(0, 255)));
    end
  endtask

  task automatic test_directed_heads();
    send_byte({MAJOR_UINT, 5'd0});
    send_byte({MAJOR_UINT, 5'd23});
    send_byte({MAJOR_UINT, INFO_ONE_BYTE});
    send_byte(8'hff);
    send_byte({MAJOR_NEGINT, INFO_TWO_BYTE});
    send_byte(8'h01);
    send_byte(8'h00);
    // eight-byte negative integer, then back to heads
    send_byte({MAJOR_NEGINT, INFO_EIGHT_BYTE});
    repeat (8) send_byte(8'hff);
    // empty string
    send_byte({MAJOR_BYTES, 5'd0});
    send_byte({MAJOR_TEXT, 5'd1});
    send_byte(8'h7f);
    send_byte({MAJOR_ARRAY, 5'd0});
    send_byte({MAJOR_MAP, 5'd23});
    send_byte({MAJOR_TAG, 5'd1});
    send_byte({MAJOR_SIMPLE, INFO_ONE_BYTE});
    send_byte(8'hff);
  endtask

  task automatic test_random_stream();
    while (bytes_sent < STREAM_BYTES) begin
      if ($urandom_range(0, 49) == 0) begin
        src_calm = ~src_calm;
      end
      if ($urandom_range(0, 9) < 8) begin
        sync_to_head();
        send_head_item();
      end else begin
        repeat ($urandom_range(1, 6)) send_noise();
      end
    end
    src_calm = 1'b0;
  endtask

  // the error mode holds until reset, so this runs last
  task automatic test_sticky_error();
    logic [2:0] maj;
    sync_to_head();
    if ($urandom_range(0, 1) == 0) begin
      maj = 3'($urandom_range(0, 7));
      send_byte({maj, 5'($urandom_range(INFO_RESERVED_MIN, INFO_RESERVED_MAX))});
    end else begin
      maj = 3'($urandom_range(MAJOR_BYTES, MAJOR_MAP));
      send_byte({maj, INFO_EIGHT_BYTE});
    end
    repeat (16) send_byte(8'($urandom_range(0, 255)));
  endtask

  // event sink: random back-pressure and in-order check
  initial begin
    int         stall_left;
    csd_event_t want;
    out_if.ready = 1'b0;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_if.valid && out_if.ready) begin
        if (event_q.size() == 0) begin
          $error("unexpected event kind %0d arg %0h", out_if.event_kind, out_if.arg_value);
          err_cnt++;
        end else begin
          want = event_q.pop_front();
          if (out_if.event_kind !== want.kind) begin
            $error("event_kind expected %0d got %0d", want.kind, out_if.event_kind);
            err_cnt++;
          end
          if (out_if.arg_value !== want.arg) begin
            $error("arg_value expected %0h got %0h", want.arg, out_if.arg_value);
            err_cnt++;
          end
          if (out_if.payload_byte !== want.pbyte) begin
            $error("payload_byte expected %0h got %0h", want.pbyte, out_if.payload_byte);
            err_cnt++;
          end
          if (out_if.payload_last !== want.plast) begin
            $error("payload_last expected %0b got %0b", want.plast, out_if.payload_last);
            err_cnt++;
          end
          if (out_if.error_code !== want.ecode) begin
            $error("error_code expected %0b got %0b", want.ecode, out_if.error_code);
            err_cnt++;
          end
        end
      end
      if ($urandom_range(0, 199) == 0) begin
        snk_calm = ~snk_calm;
      end
      if (stall_left > 0) begin
        out_if.ready <= 1'b0;
        stall_left--;
      end else begin
        out_if.ready <= 1'b1;
        if (!snk_calm && $urandom_range(0, 3) == 0) begin
          stall_left = pick_gap();
        end
      end
    end
  end

  initial begin
    in_if.valid = 1'b0;
    in_if.in_byte = 8'h00;
    rst_n = 1'b0;
    err_cnt = 0;
    bytes_sent = 0;
    cycle_cnt = 0;
    src_calm = 1'b0;
    snk_calm = 1'b0;
    dec_mode = PM_HEADER;
    dec_major = MAJOR_UINT;
    dec_arg_left = '0;
    dec_arg = '0;
    dec_str_left = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_heads();
    test_random_stream();
    test_sticky_error();

    in_if.valid <= 1'b0;
    while (event_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_cnt == 0) begin
      $display("cbor_stream_decoder verification clean");
    end else begin
      $display("cbor_stream_decoder verification failed");
    end
    $finish;
  end

endmodule
